/* src/assert_macros.svh */
// Assertion macros used by the RTL of the segment intersection test.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

/* src/sit_pkg.sv */
// Package with the shared types and constants of the segment intersection test.
`timescale 1ns / 1ps

package sit_pkg;

   typedef struct packed {
      logic neg;
      logic zero;
   } sign_type;

   localparam int unsigned LATENCY = 6;
   localparam int unsigned NCROSS  = 7;

   function automatic logic opposite(sign_type s, sign_type t);
      return (s.neg && !t.neg && !t.zero) || (t.neg && !s.neg && !s.zero);
   endfunction

endpackage

/* src/segment_intersection_test.sv */
// Top level of the segment intersection test: a pipelined cross-product datapath.
// Throughput: one transfer per cycle; busy is always low and the pipeline never stalls.
// The six stages are input capture, end point ordering, segment swap, differences,
// products and sign evaluation; the products stage holds the 14 multipliers.
// Reset clears all valid bits synchronously; payload registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module segment_intersection_test
   import sit_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [COORD_WIDTH-1:0] req_a_x,
   input  logic [COORD_WIDTH-1:0] req_a_y,
   input  logic [COORD_WIDTH-1:0] req_b_x,
   input  logic [COORD_WIDTH-1:0] req_b_y,
   input  logic [COORD_WIDTH-1:0] req_c_x,
   input  logic [COORD_WIDTH-1:0] req_c_y,
   input  logic [COORD_WIDTH-1:0] req_d_x,
   input  logic [COORD_WIDTH-1:0] req_d_y,
   output logic                   rsp_strobe,
   output logic                   rsp_crosses
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int CW = PW + 1;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
   } pt_type;

   typedef struct packed {
      logic [DW-1:0] x;
      logic [DW-1:0] y;
   } vec_type;

   function automatic logic lex_gt(pt_type p, pt_type q);
      return ($signed(p.x) > $signed(q.x)) || ((p.x == q.x) && ($signed(p.y) > $signed(q.y)));
   endfunction

   function automatic vec_type diff(pt_type p, pt_type q);
      vec_type r;
      r.x = {p.x[COORD_WIDTH-1], p.x} - {q.x[COORD_WIDTH-1], q.x};
      r.y = {p.y[COORD_WIDTH-1], p.y} - {q.y[COORD_WIDTH-1], q.y};
      return r;
   endfunction

   // Stage 1: input capture.
   logic   v1_ff;
   pt_type a1_ff, b1_ff, c1_ff, d1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      a1_ff <= '{x: req_a_x, y: req_a_y};
      b1_ff <= '{x: req_b_x, y: req_b_y};
      c1_ff <= '{x: req_c_x, y: req_c_y};
      d1_ff <= '{x: req_d_x, y: req_d_y};
   end

   assign busy = 1'b0;

   // Stage 2: each segment in lexicographic order.
   logic   v2_ff;
   pt_type a2_ff, b2_ff, c2_ff, d2_ff;
   logic   swap_ab, swap_cd;

   assign swap_ab = lex_gt(a1_ff, b1_ff);
   assign swap_cd = lex_gt(c1_ff, d1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      a2_ff <= swap_ab ? b1_ff : a1_ff;
      b2_ff <= swap_ab ? a1_ff : b1_ff;
      c2_ff <= swap_cd ? d1_ff : c1_ff;
      d2_ff <= swap_cd ? c1_ff : d1_ff;
   end

   // Stage 3: the segment that starts first comes first.
   logic   v3_ff;
   pt_type a3_ff, b3_ff, c3_ff, d3_ff;
   logic   swap_seg;
   logic   order_ok;

   assign swap_seg = lex_gt(a2_ff, c2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      a3_ff <= swap_seg ? c2_ff : a2_ff;
      b3_ff <= swap_seg ? d2_ff : b2_ff;
      c3_ff <= swap_seg ? a2_ff : c2_ff;
      d3_ff <= swap_seg ? b2_ff : d2_ff;
   end

   assign order_ok = !lex_gt(a3_ff, b3_ff) && !lex_gt(c3_ff, d3_ff) && !lex_gt(a3_ff, c3_ff);

   // Stage 4: difference vectors, in the order of the cross products below.
   logic    v4_ff;
   logic    c_le_b4_ff;
   vec_type u4_ff [NCROSS];
   vec_type w4_ff [NCROSS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      c_le_b4_ff <= !lex_gt(c3_ff, b3_ff);
      u4_ff[0]   <= diff(b3_ff, a3_ff);
      w4_ff[0]   <= diff(d3_ff, c3_ff);
      u4_ff[1]   <= diff(c3_ff, b3_ff);
      w4_ff[1]   <= diff(d3_ff, c3_ff);
      u4_ff[2]   <= diff(b3_ff, a3_ff);
      w4_ff[2]   <= diff(c3_ff, a3_ff);
      u4_ff[3]   <= diff(c3_ff, a3_ff);
      w4_ff[3]   <= diff(b3_ff, a3_ff);
      u4_ff[4]   <= diff(d3_ff, a3_ff);
      w4_ff[4]   <= diff(b3_ff, a3_ff);
      u4_ff[5]   <= diff(a3_ff, c3_ff);
      w4_ff[5]   <= diff(d3_ff, c3_ff);
      u4_ff[6]   <= diff(b3_ff, c3_ff);
      w4_ff[6]   <= diff(d3_ff, c3_ff);
   end

   // Stage 5: the two products of each cross product.
   logic             v5_ff;
   logic             c_le_b5_ff;
   logic [PW-1:0]    pa5_ff [NCROSS];
   logic [PW-1:0]    pb5_ff [NCROSS];
   logic signed [PW-1:0] pa_in [NCROSS];
   logic signed [PW-1:0] pb_in [NCROSS];

   for (genvar i = 0; i < NCROSS; i++) begin : g_mul
      assign pa_in[i] = $signed(u4_ff[i].x) * $signed(w4_ff[i].y);
      assign pb_in[i] = $signed(u4_ff[i].y) * $signed(w4_ff[i].x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      c_le_b5_ff <= c_le_b4_ff;
      for (int i = 0; i < NCROSS; i++) begin
         pa5_ff[i] <= pa_in[i];
         pb5_ff[i] <= pb_in[i];
      end
   end

   // Stage 6: signs of the cross products and the decision.
   logic [CW-1:0] cross_diff [NCROSS];
   sign_type      sgn [NCROSS];
   logic          crosses_in;
   logic          rsp_strobe_ff;
   logic          rsp_crosses_ff;

   for (genvar i = 0; i < NCROSS; i++) begin : g_sign
      assign cross_diff[i] = {pa5_ff[i][PW-1], pa5_ff[i]} - {pb5_ff[i][PW-1], pb5_ff[i]};
      assign sgn[i].neg    = cross_diff[i][CW-1];
      assign sgn[i].zero   = (cross_diff[i] == '0);
   end

   always_comb begin
      if (sgn[0].zero) begin
         crosses_in = sgn[1].zero && sgn[2].zero && c_le_b5_ff;
      end else begin
         crosses_in = opposite(sgn[3], sgn[4]) && opposite(sgn[5], sgn[6]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= v5_ff;
      end
      rsp_crosses_ff <= crosses_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_crosses = rsp_crosses_ff;

   `ASSERT_IMPLY(a_strobe_follows_start, rsp_strobe, $past(start, LATENCY))
   `ASSERT_IMPLY(a_points_ordered, v3_ff, order_ok)
   `ASSERT_NEXT(a_parallel_gap_misses, v5_ff && sgn[0].zero && !c_le_b5_ff, !rsp_crosses)

endmodule
